// ----- sv/ptl_pkg.sv -----
// Shared types, register codes and reset constants for the primer trim locator.
package ptl_pkg;

    localparam int READ_MAX_DEF   = 512;
    localparam int PRIMER_LEN_DEF = 10;

    localparam int PRIMER_W  = 20;
    localparam int LEN_W     = 10;
    localparam int TOL_W     = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [PRIMER_W-1:0] HEAD_PRIMER_RST    = 20'd542851; // TAAGAGACAG
    localparam logic [PRIMER_W-1:0] TAIL_PRIMER_RST    = 20'd253421; // CTGTCTCTTA
    localparam logic [LEN_W-1:0]    PAYLOAD_LENGTH_RST = 10'd140;
    localparam logic [TOL_W-1:0]    TOLERANCE_RST      = 6'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_PRIMER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_PRIMER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 2'd3;

    // match case codes
    localparam logic [1:0] MATCH_BOTH  = 2'd0;
    localparam logic [1:0] MATCH_FRONT = 2'd1;
    localparam logic [1:0] MATCH_BACK  = 2'd2;
    localparam logic [1:0] MATCH_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0] base;
        logic       not_base;
        logic       last;
    } ptl_sym_t;

    typedef struct packed {
        logic             accepted;
        logic             reverse_strand;
        logic [1:0]       match_case;
        logic [LEN_W-1:0] payload_start;
        logic [LEN_W-1:0] payload_len;
        logic             too_long;
    } ptl_desc_t;

endpackage

// ----- sv/primer_trim_locator.sv -----
// Top level of the primer trim locator: config registers, scanner and result pipeline.
//
// Usage:
//   sym channel (sym_valid/sym_ready/sym) carries one read symbol per transaction:
//   a 2-bit base, a not_base flag for non-ACGT symbols and a last flag on the
//   final symbol of the read. One transaction per cycle is sustained while sym_ready stays high.
//   desc channel (desc_valid/desc_ready/desc) carries one descriptor per read:
//   strand, match case, payload start/length, accept and too_long flags.
//   The descriptor passes through the scanner snapshot, orientation select,
//   locate and tolerance check registers after the last symbol is taken.
//   Each stage holds its item while the next is full, so reads
//   keep streaming while a descriptor waits; when the receiver stalls long
//   enough to fill the three result stages and the snapshot, sym_ready drops.
//   Config port: cfg_wr_en writes cfg_wdata into register cfg_index
//   (front primer, back primer, expected payload length, tolerance);
//   write only while no read is in flight.
//   Reset restores the default primers, length 140 and tolerance 5, and
//   clears the read state; nothing is pending after reset.
module primer_trim_locator #(
    parameter int READ_MAX   = ptl_pkg::READ_MAX_DEF,
    parameter int PRIMER_LEN = ptl_pkg::PRIMER_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ptl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptl_pkg::PRIMER_W-1:0]    cfg_wdata,
    input  logic                            sym_valid,
    output logic                            sym_ready,
    input  ptl_pkg::ptl_sym_t               sym,
    output logic                            desc_valid,
    input  logic                            desc_ready,
    output ptl_pkg::ptl_desc_t              desc
);
    import ptl_pkg::*;

    localparam int CW = $clog2(READ_MAX + 1);

    // configuration registers
    logic [PRIMER_W-1:0] head_primer_reg;
    logic [PRIMER_W-1:0] tail_primer_reg;
    logic [LEN_W-1:0]    payload_length_reg;
    logic [TOL_W-1:0]    tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_primer_reg    <= HEAD_PRIMER_RST;
            tail_primer_reg    <= TAIL_PRIMER_RST;
            payload_length_reg <= PAYLOAD_LENGTH_RST;
            tolerance_reg      <= TOLERANCE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_HEAD_PRIMER:    head_primer_reg    <= cfg_wdata;
                CFG_TAIL_PRIMER:    tail_primer_reg    <= cfg_wdata;
                CFG_PAYLOAD_LENGTH: payload_length_reg <= cfg_wdata[LEN_W-1:0];
                CFG_TOLERANCE:      tolerance_reg      <= cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // end-of-read snapshot between scanner and result pipeline
    logic          snap_valid, snap_ready;
    logic [CW-1:0] snap_read_count, snap_filt_count;
    logic          snap_ff_found, snap_bf_found, snap_rf_found, snap_rb_found;
    logic [CW-1:0] snap_ff_pos, snap_bf_pos, snap_rf_pos, snap_rb_pos;
    logic          snap_overflow;

    ptl_scan #(
        .READ_MAX   (READ_MAX),
        .PRIMER_LEN (PRIMER_LEN)
    ) u_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_primer     (head_primer_reg),
        .tail_primer     (tail_primer_reg),
        .sym_valid       (sym_valid),
        .sym_ready       (sym_ready),
        .sym             (sym),
        .snap_valid      (snap_valid),
        .snap_ready      (snap_ready),
        .snap_read_count (snap_read_count),
        .snap_filt_count (snap_filt_count),
        .snap_ff_found   (snap_ff_found),
        .snap_ff_pos     (snap_ff_pos),
        .snap_bf_found   (snap_bf_found),
        .snap_bf_pos     (snap_bf_pos),
        .snap_rf_found   (snap_rf_found),
        .snap_rf_pos     (snap_rf_pos),
        .snap_rb_found   (snap_rb_found),
        .snap_rb_pos     (snap_rb_pos),
        .snap_overflow   (snap_overflow)
    );

    ptl_result #(
        .READ_MAX   (READ_MAX),
        .PRIMER_LEN (PRIMER_LEN)
    ) u_result (
        .clk             (clk),
        .rst_n           (rst_n),
        .payload_length  (payload_length_reg),
        .tolerance       (tolerance_reg),
        .snap_valid      (snap_valid),
        .snap_ready      (snap_ready),
        .snap_read_count (snap_read_count),
        .snap_filt_count (snap_filt_count),
        .snap_ff_found   (snap_ff_found),
        .snap_ff_pos     (snap_ff_pos),
        .snap_bf_found   (snap_bf_found),
        .snap_bf_pos     (snap_bf_pos),
        .snap_rf_found   (snap_rf_found),
        .snap_rf_pos     (snap_rf_pos),
        .snap_rb_found   (snap_rb_found),
        .snap_rb_pos     (snap_rb_pos),
        .snap_overflow   (snap_overflow),
        .desc_valid      (desc_valid),
        .desc_ready      (desc_ready),
        .desc            (desc)
    );

endmodule

// ----- sv/ptl_scan.sv -----
// Per-symbol primer window scanner; snapshots the match state at end of read.
module ptl_scan #(
    parameter int READ_MAX   = ptl_pkg::READ_MAX_DEF,
    parameter int PRIMER_LEN = ptl_pkg::PRIMER_LEN_DEF,
    localparam int CW        = $clog2(READ_MAX + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ptl_pkg::PRIMER_W-1:0]  head_primer,
    input  logic [ptl_pkg::PRIMER_W-1:0]  tail_primer,
    input  logic                          sym_valid,
    output logic                          sym_ready,
    input  ptl_pkg::ptl_sym_t             sym,
    output logic                          snap_valid,
    input  logic                          snap_ready,
    output logic [CW-1:0]                 snap_read_count,
    output logic [CW-1:0]                 snap_filt_count,
    output logic                          snap_ff_found,
    output logic [CW-1:0]                 snap_ff_pos,
    output logic                          snap_bf_found,
    output logic [CW-1:0]                 snap_bf_pos,
    output logic                          snap_rf_found,
    output logic [CW-1:0]                 snap_rf_pos,
    output logic                          snap_rb_found,
    output logic [CW-1:0]                 snap_rb_pos,
    output logic                          snap_overflow
);
    import ptl_pkg::*;

    localparam int WW = 2 * PRIMER_LEN;
    localparam logic [CW-1:0] L_C   = CW'(PRIMER_LEN);
    localparam logic [CW-1:0] MAX_C = CW'(READ_MAX);

    logic [WW-1:0]         fwd_reg, fwd_next;
    logic [PRIMER_LEN-1:0] mask_reg, mask_next;
    logic [WW-1:0]         filt_reg, filt_next;
    logic [CW-1:0]         rc_reg, rc_next;
    logic [CW-1:0]         fc_reg, fc_next;
    logic                  ff_found_reg, ff_found_next;
    logic [CW-1:0]         ff_pos_reg, ff_pos_next;
    logic                  bf_found_reg, bf_found_next;
    logic [CW-1:0]         bf_pos_reg, bf_pos_next;
    logic                  rf_found_reg, rf_found_next;
    logic [CW-1:0]         rf_pos_reg, rf_pos_next;
    logic                  rb_found_reg, rb_found_next;
    logic [CW-1:0]         rb_pos_reg, rb_pos_next;
    logic                  ovf_reg, ovf_next;

    logic                  snap_valid_reg;
    logic                  take;

    logic [WW+PRIMER_W-1:0] fp_ext, bp_ext;
    logic [WW-1:0]          fp, bp, rc_fp, rc_bp;
    logic [CW-1:0]          fwd_pos, filt_pos;

    // primers cut or zero-extended to the window width
    assign fp_ext = {{WW{1'b0}}, head_primer};
    assign bp_ext = {{WW{1'b0}}, tail_primer};
    assign fp     = fp_ext[WW-1:0];
    assign bp     = bp_ext[WW-1:0];

    always_comb
    begin
        for (int i = 0; i < PRIMER_LEN; i++)
        begin
            rc_fp[2*i +: 2] = ~fp[2*(PRIMER_LEN-1-i) +: 2];
            rc_bp[2*i +: 2] = ~bp[2*(PRIMER_LEN-1-i) +: 2];
        end
    end

    assign fwd_pos  = rc_next - L_C;
    assign filt_pos = fc_next - L_C;

    always_comb
    begin
        fwd_next      = fwd_reg;
        mask_next     = mask_reg;
        filt_next     = filt_reg;
        rc_next       = rc_reg;
        fc_next       = fc_reg;
        ff_found_next = ff_found_reg;
        ff_pos_next   = ff_pos_reg;
        bf_found_next = bf_found_reg;
        bf_pos_next   = bf_pos_reg;
        rf_found_next = rf_found_reg;
        rf_pos_next   = rf_pos_reg;
        rb_found_next = rb_found_reg;
        rb_pos_next   = rb_pos_reg;
        ovf_next      = ovf_reg;
        if (rc_reg < MAX_C)
        begin
            fwd_next  = {sym.base, fwd_reg[WW-1:2]};
            mask_next = {~sym.not_base, mask_reg[PRIMER_LEN-1:1]};
            rc_next   = rc_reg + 1'b1;
            if (&mask_next)
            begin
                if (!ff_found_reg && fwd_next == fp)
                begin
                    ff_found_next = 1'b1;
                    ff_pos_next   = fwd_pos;
                end
                if (!bf_found_reg && fwd_next == bp)
                begin
                    bf_found_next = 1'b1;
                    bf_pos_next   = fwd_pos;
                end
            end
            if (!sym.not_base)
            begin
                filt_next = {sym.base, filt_reg[WW-1:2]};
                fc_next   = fc_reg + 1'b1;
                if (fc_next >= L_C)
                begin
                    // last hit wins on the filtered strand
                    if (filt_next == rc_fp)
                    begin
                        rf_found_next = 1'b1;
                        rf_pos_next   = filt_pos;
                    end
                    if (filt_next == rc_bp)
                    begin
                        rb_found_next = 1'b1;
                        rb_pos_next   = filt_pos;
                    end
                end
            end
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    assign sym_ready = !snap_valid_reg || snap_ready;
    assign take      = sym_valid && sym_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg        <= '0;
            mask_reg       <= '0;
            filt_reg       <= '0;
            rc_reg         <= '0;
            fc_reg         <= '0;
            ff_found_reg   <= 1'b0;
            ff_pos_reg     <= '0;
            bf_found_reg   <= 1'b0;
            bf_pos_reg     <= '0;
            rf_found_reg   <= 1'b0;
            rf_pos_reg     <= '0;
            rb_found_reg   <= 1'b0;
            rb_pos_reg     <= '0;
            ovf_reg        <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (take && sym.last)
            begin
                snap_valid_reg <= 1'b1;
            end
            else if (snap_ready)
            begin
                snap_valid_reg <= 1'b0;
            end
            if (take)
            begin
                if (sym.last)
                begin
                    fwd_reg        <= '0;
                    mask_reg       <= '0;
                    filt_reg       <= '0;
                    rc_reg         <= '0;
                    fc_reg         <= '0;
                    ff_found_reg   <= 1'b0;
                    ff_pos_reg     <= '0;
                    bf_found_reg   <= 1'b0;
                    bf_pos_reg     <= '0;
                    rf_found_reg   <= 1'b0;
                    rf_pos_reg     <= '0;
                    rb_found_reg   <= 1'b0;
                    rb_pos_reg     <= '0;
                    ovf_reg        <= 1'b0;
                end
                else
                begin
                    fwd_reg      <= fwd_next;
                    mask_reg     <= mask_next;
                    filt_reg     <= filt_next;
                    rc_reg       <= rc_next;
                    fc_reg       <= fc_next;
                    ff_found_reg <= ff_found_next;
                    ff_pos_reg   <= ff_pos_next;
                    bf_found_reg <= bf_found_next;
                    bf_pos_reg   <= bf_pos_next;
                    rf_found_reg <= rf_found_next;
                    rf_pos_reg   <= rf_pos_next;
                    rb_found_reg <= rb_found_next;
                    rb_pos_reg   <= rb_pos_next;
                    ovf_reg      <= ovf_next;
                end
            end
        end
    end

    // end-of-read snapshot (payload only)
    always_ff @(posedge clk)
    begin
        if (take && sym.last)
        begin
            snap_read_count <= rc_next;
            snap_filt_count <= fc_next;
            snap_ff_found   <= ff_found_next;
            snap_ff_pos     <= ff_pos_next;
            snap_bf_found   <= bf_found_next;
            snap_bf_pos     <= bf_pos_next;
            snap_rf_found   <= rf_found_next;
            snap_rf_pos     <= rf_pos_next;
            snap_rb_found   <= rb_found_next;
            snap_rb_pos     <= rb_pos_next;
            snap_overflow   <= ovf_next;
        end
    end

    assign snap_valid = snap_valid_reg;

endmodule

// ----- sv/ptl_result.sv -----
// Descriptor pipeline: orientation select, payload locate, tolerance check.
module ptl_result #(
    parameter int READ_MAX   = ptl_pkg::READ_MAX_DEF,
    parameter int PRIMER_LEN = ptl_pkg::PRIMER_LEN_DEF,
    localparam int CW        = $clog2(READ_MAX + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ptl_pkg::LEN_W-1:0]   payload_length,
    input  logic [ptl_pkg::TOL_W-1:0]   tolerance,
    input  logic                        snap_valid,
    output logic                        snap_ready,
    input  logic [CW-1:0]               snap_read_count,
    input  logic [CW-1:0]               snap_filt_count,
    input  logic                        snap_ff_found,
    input  logic [CW-1:0]               snap_ff_pos,
    input  logic                        snap_bf_found,
    input  logic [CW-1:0]               snap_bf_pos,
    input  logic                        snap_rf_found,
    input  logic [CW-1:0]               snap_rf_pos,
    input  logic                        snap_rb_found,
    input  logic [CW-1:0]               snap_rb_pos,
    input  logic                        snap_overflow,
    output logic                        desc_valid,
    input  logic                        desc_ready,
    output ptl_pkg::ptl_desc_t          desc
);
    import ptl_pkg::*;

    localparam int VW = (CW > LEN_W) ? CW : LEN_W;
    localparam logic [CW-1:0] L_C  = CW'(PRIMER_LEN);
    localparam logic [VW-1:0] L_VW = VW'(PRIMER_LEN);

    // pipeline control
    logic sel_valid_reg, loc_valid_reg, desc_valid_reg;
    logic out_load, loc_load, sel_load;

    assign out_load   = !desc_valid_reg || desc_ready;
    assign loc_load   = !loc_valid_reg || out_load;
    assign sel_load   = !sel_valid_reg || loc_load;
    assign snap_ready = sel_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg  <= 1'b0;
            loc_valid_reg  <= 1'b0;
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            if (sel_load)
            begin
                sel_valid_reg <= snap_valid;
            end
            if (loc_load)
            begin
                loc_valid_reg <= sel_valid_reg;
            end
            if (out_load)
            begin
                desc_valid_reg <= loc_valid_reg;
            end
        end
    end

    // stage 1: orientation; reverse positions map to m - L - j
    logic          sel_rev_reg, sel_rev_next;
    logic          sel_f_found_reg, sel_f_found_next;
    logic [CW-1:0] sel_f_pos_reg, sel_f_pos_next;
    logic          sel_b_found_reg, sel_b_found_next;
    logic [CW-1:0] sel_b_pos_reg, sel_b_pos_next;
    logic [CW-1:0] sel_n_reg, sel_n_next;
    logic          sel_ovf_reg;

    always_comb
    begin
        sel_rev_next = !(snap_ff_found || snap_bf_found);
        if (!sel_rev_next)
        begin
            sel_f_found_next = snap_ff_found;
            sel_f_pos_next   = snap_ff_pos;
            sel_b_found_next = snap_bf_found;
            sel_b_pos_next   = snap_bf_pos;
            sel_n_next       = snap_read_count;
        end
        else
        begin
            sel_f_found_next = snap_rf_found;
            sel_f_pos_next   = snap_filt_count - L_C - snap_rf_pos;
            sel_b_found_next = snap_rb_found;
            sel_b_pos_next   = snap_filt_count - L_C - snap_rb_pos;
            sel_n_next       = snap_filt_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_load && snap_valid)
        begin
            sel_rev_reg     <= sel_rev_next;
            sel_f_found_reg <= sel_f_found_next;
            sel_f_pos_reg   <= sel_f_pos_next;
            sel_b_found_reg <= sel_b_found_next;
            sel_b_pos_reg   <= sel_b_pos_next;
            sel_n_reg       <= sel_n_next;
            sel_ovf_reg     <= snap_overflow;
        end
    end

    // stage 2: payload start and length
    logic [VW-1:0] f_pos, b_pos, n_val, lib, s_val, rest;
    logic [1:0]    mcase_next;
    logic [VW-1:0] start_next, len_next;
    logic [1:0]    loc_mcase_reg;
    logic [VW-1:0] loc_start_reg, loc_len_reg;
    logic          loc_rev_reg, loc_ovf_reg;

    assign f_pos = VW'(sel_f_pos_reg);
    assign b_pos = VW'(sel_b_pos_reg);
    assign n_val = VW'(sel_n_reg);
    assign lib   = VW'(payload_length);
    assign s_val = f_pos + L_VW;
    assign rest  = (n_val > s_val) ? n_val - s_val : '0;

    always_comb
    begin
        mcase_next = MATCH_NONE;
        start_next = '0;
        len_next   = '0;
        if (sel_f_found_reg)
        begin
            start_next = s_val;
            if (sel_b_found_reg)
            begin
                // back primer starts before the end of the front primer: take the rest
                mcase_next = MATCH_BOTH;
                len_next   = (b_pos >= s_val) ? b_pos - s_val : rest;
            end
            else
            begin
                mcase_next = MATCH_FRONT;
                len_next   = (lib < rest) ? lib : rest;
            end
        end
        else if (sel_b_found_reg)
        begin
            mcase_next = MATCH_BACK;
            start_next = (b_pos > lib) ? b_pos - lib : '0;
            len_next   = (b_pos > lib) ? lib : b_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (loc_load && sel_valid_reg)
        begin
            loc_mcase_reg <= mcase_next;
            loc_start_reg <= start_next;
            loc_len_reg   <= len_next;
            loc_rev_reg   <= sel_rev_reg;
            loc_ovf_reg   <= sel_ovf_reg;
        end
    end

    // stage 3: tolerance check
    logic [VW-1:0] diff;
    logic          acc_next;
    ptl_desc_t     desc_reg;

    assign diff = (loc_len_reg > lib) ? loc_len_reg - lib : lib - loc_len_reg;
    assign acc_next = (loc_mcase_reg != MATCH_NONE) && (diff <= VW'(tolerance))
                      && (loc_len_reg != '0);

    always_ff @(posedge clk)
    begin
        if (out_load && loc_valid_reg)
        begin
            desc_reg.accepted       <= acc_next;
            desc_reg.reverse_strand <= loc_rev_reg;
            desc_reg.match_case     <= loc_mcase_reg;
            desc_reg.payload_start  <= loc_start_reg[LEN_W-1:0];
            desc_reg.payload_len    <= loc_len_reg[LEN_W-1:0];
            desc_reg.too_long       <= loc_ovf_reg;
        end
    end

    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

endmodule
